### rtl/lfps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PD steering package
// Shared widths, register indexes, a helper function and the command and
// status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package lfps_pkg;

  localparam int SENSOR_COUNT_DEF = 8;

  localparam int LEVEL_W    = 8;   // raw sensor levels per request
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int SPEED_W    = 16;  // base speed and left command
  localparam int LIMIT_W    = 15;  // speed limit and right command
  localparam int ERR_W      = 4;
  localparam int ERR_MAX    = 7;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLACK_LEVEL   = 3'd0,
    CFG_PROP_GAIN     = 3'd1,
    CFG_DERIV_GAIN    = 3'd2,
    CFG_BASE_SPEED    = 3'd3,
    CFG_SPEED_LIMIT   = 3'd4,
    CFG_SENSORS_READY = 3'd5
  } cfg_reg_t;

  // Bits needed for the largest weight sum magnitude, about n*n/4.
  function automatic int mag_w(input int n);
    return $clog2(n * n / 4 + 1);
  endfunction

  typedef struct packed {
    logic start;     // latch sensor levels, clear sum and count
    logic scan_en;   // accumulate one sensor
    logic div_init;  // load divider from the sum
    logic div_step;  // one restoring division step
    logic err_load;  // form the line error, update last good error
    logic mul_p;     // acc = prop_gain * error
    logic mul_d;     // acc += deriv_gain * delta, update previous error
    logic turn_en;   // scale accumulator to turn
    logic speed_en;  // form clamped wheel speeds
    logic out_load;  // load the output register
    logic out_stop;  // load the stop result instead
  } lfps_cmd_t;

  typedef struct packed {
    logic sensors_ready;
    logic out_busy;
  } lfps_sts_t;

endpackage

### rtl/lfps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower controller
// Sequences sensor scan, division, PD multiply and output load per request.
// ----------------------------------------------------------------------------
module lfps_ctrl #(
  parameter int SENSOR_COUNT = lfps_pkg::SENSOR_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lfps_pkg::lfps_sts_t         sts,
  output lfps_pkg::lfps_cmd_t         cmd,
  output logic [$clog2(SENSOR_COUNT)-1:0] idx
);
  import lfps_pkg::*;

  localparam int IDX_W = $clog2(SENSOR_COUNT);
  localparam int MAG_W = mag_w(SENSOR_COUNT);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SCAN  = 10'b00_0000_0010,
    S_DIVI  = 10'b00_0000_0100,
    S_DIV   = 10'b00_0000_1000,
    S_ERR   = 10'b00_0001_0000,
    S_MULP  = 10'b00_0010_0000,
    S_MULD  = 10'b00_0100_0000,
    S_TURN  = 10'b00_1000_0000,
    S_SPEED = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] ctr_r, ctr_nxt;
  logic             stop_r, stop_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign idx      = ctr_r;

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    stop_nxt  = stop_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctr_nxt = '0;
          if (sts.sensors_ready) begin
            cmd.start = 1'b1;
            stop_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end else begin
            stop_nxt  = 1'b1;
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (ctr_r == IDX_W'(SENSOR_COUNT - 1)) begin
          ctr_nxt   = '0;
          state_nxt = S_DIVI;
        end else begin
          ctr_nxt = ctr_r + 1'b1;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (ctr_r == IDX_W'(MAG_W - 1)) begin
          ctr_nxt   = '0;
          state_nxt = S_ERR;
        end else begin
          ctr_nxt = ctr_r + 1'b1;
        end
      end
      S_ERR: begin
        cmd.err_load = 1'b1;
        state_nxt    = S_MULP;
      end
      S_MULP: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.mul_d = 1'b1;
        state_nxt = S_TURN;
      end
      S_TURN: begin
        cmd.turn_en = 1'b1;
        state_nxt   = S_SPEED;
      end
      S_SPEED: begin
        cmd.speed_en = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_stop = stop_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ctr_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      stop_r  <= stop_nxt;
    end
  end

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN || state_r == S_DONE))
    else $error("accepted request did not start scan or stop path");

  a_err_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR) |-> ($past(state_r) == S_DIV && $past(ctr_r) == IDX_W'(MAG_W - 1)))
    else $error("error formed before division finished");

endmodule

### rtl/lfps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower datapath
// Configuration registers, weight accumulator, restoring divider, shared
// multiplier, speed clamps and the output register.
// ----------------------------------------------------------------------------
module lfps_dp #(
  parameter int SENSOR_COUNT = lfps_pkg::SENSOR_COUNT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [lfps_pkg::LEVEL_W-1:0]          in_sensor_levels,
  input  lfps_pkg::lfps_cmd_t                   cmd,
  input  logic [$clog2(SENSOR_COUNT)-1:0]       idx,
  output lfps_pkg::lfps_sts_t                   sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [lfps_pkg::ERR_W-1:0]     out_line_error,
  output logic                                  out_line_lost,
  output logic [lfps_pkg::LEVEL_W-1:0]          out_on_line_mask,
  output logic                                  out_stop_all,
  output logic [lfps_pkg::LIMIT_W-1:0]          out_right_command,
  output logic signed [lfps_pkg::SPEED_W-1:0]   out_left_command
);
  import lfps_pkg::*;

  localparam int N      = SENSOR_COUNT;
  localparam int MAG_W  = mag_w(N);
  localparam int SUM_W  = MAG_W + 1;
  localparam int CNT_W  = $clog2(N + 1);
  localparam int MUL_AW = GAIN_W + 1;
  localparam int MUL_BW = ERR_W + 1;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int PD_W   = PROD_W + 2;

  // Configuration.
  logic                      black_r;
  logic [GAIN_W-1:0]         pgain_r;
  logic [GAIN_W-1:0]         dgain_r;
  logic signed [SPEED_W-1:0] base_r;
  logic [LIMIT_W-1:0]        limit_r;
  logic                      ready_r;

  // Working state.
  logic [LEVEL_W-1:0]        lvl_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          rem_r;
  logic [MAG_W-1:0]          quo_r;
  logic signed [ERR_W-1:0]   err_r;
  logic                      lost_r;
  logic signed [ERR_W-1:0]   last_good_r;
  logic signed [ERR_W-1:0]   prev_r;
  logic signed [PD_W-1:0]    acc_r;
  logic signed [SPEED_W-1:0] turn_r;
  logic [LIMIT_W-1:0]        left_r;
  logic [LIMIT_W-1:0]        right_r;

  // Output register.
  logic                      out_valid_r;
  logic signed [ERR_W-1:0]   out_err_r;
  logic                      out_lost_r;
  logic [LEVEL_W-1:0]        out_mask_r;
  logic                      out_stop_r;
  logic [LIMIT_W-1:0]        out_right_r;
  logic signed [SPEED_W-1:0] out_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      black_r <= 1'b0;
      pgain_r <= '0;
      dgain_r <= '0;
      base_r  <= '0;
      limit_r <= '0;
      ready_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BLACK_LEVEL:   black_r <= cfg_data[0];
        CFG_PROP_GAIN:     pgain_r <= cfg_data;
        CFG_DERIV_GAIN:    dgain_r <= cfg_data;
        CFG_BASE_SPEED:    base_r  <= cfg_data;
        CFG_SPEED_LIMIT:   limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_SENSORS_READY: ready_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sensor scan: sensors past the input width read as level zero.
  logic [LEVEL_W-1:0]      lvl_sh;
  logic                    hit;
  logic signed [SUM_W-1:0] weight;

  assign lvl_sh = lvl_r >> idx;
  assign hit    = (lvl_sh[0] == black_r);
  assign weight = SUM_W'(2 * int'(idx) - (N - 1));

  // Restoring divider of the sum magnitude by the hit count.
  logic [SUM_W-1:0] sum_abs;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W:0]   rem_diff;
  logic             fits;
  logic [MAG_W:0]   quo_sh;

  assign sum_abs  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign rem_sh   = {rem_r, quo_r[MAG_W-1]};
  assign rem_diff = rem_sh - {1'b0, cnt_r};
  assign fits     = (rem_sh >= {1'b0, cnt_r});
  assign quo_sh   = {quo_r, fits};

  // Averaged error, saturated for arrays of more than eight sensors.
  logic [ERR_W-2:0]        mag3;
  logic signed [ERR_W-1:0] err_new;

  always_comb begin
    if (int'(quo_r) > ERR_MAX) begin
      mag3 = (ERR_W-1)'(ERR_MAX);
    end else begin
      mag3 = (ERR_W-1)'(quo_r);
    end
    err_new = sum_r[SUM_W-1] ? -$signed({1'b0, mag3}) : $signed({1'b0, mag3});
  end

  // Shared multiplier for the proportional and derivative terms.
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] delta;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  assign delta = {err_r[ERR_W-1], err_r} - {prev_r[ERR_W-1], prev_r};
  assign mul_a = $signed({1'b0, (cmd.mul_d ? dgain_r : pgain_r)});
  assign mul_b = cmd.mul_d ? delta : {err_r[ERR_W-1], err_r};
  assign prod  = mul_a * mul_b;

  // Divide by 256 truncating toward zero. The PD sum stays well inside
  // 24 bits, so the scaled value always fits the 16-bit turn.
  logic signed [PD_W-1:0] pd_adj;
  assign pd_adj = acc_r[PD_W-1] ? (acc_r + PD_W'(255)) : acc_r;

  logic signed [SPEED_W:0] lsum;
  logic signed [SPEED_W:0] rsum;
  assign lsum = {base_r[SPEED_W-1], base_r} + {turn_r[SPEED_W-1], turn_r};
  assign rsum = {base_r[SPEED_W-1], base_r} - {turn_r[SPEED_W-1], turn_r};

  function automatic logic [LIMIT_W-1:0] clamp_speed(input logic signed [SPEED_W:0] v,
                                                     input logic [LIMIT_W-1:0] lim);
    logic [LIMIT_W-1:0] r;
    if (v[SPEED_W]) begin
      r = '0;
    end else if (v[SPEED_W-1:0] > {1'b0, lim}) begin
      r = lim;
    end else begin
      r = v[LIMIT_W-1:0];
    end
    return r;
  endfunction

  logic [LEVEL_W-1:0] mask_c;
  always_comb begin
    for (int i = 0; i < LEVEL_W; i++) begin
      mask_c[i] = (i < N) && (lvl_r[i] == black_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_good_r <= '0;
      prev_r      <= '0;
    end else begin
      if (cmd.err_load && cnt_r != '0) begin
        last_good_r <= err_new;
      end
      if (cmd.mul_d) begin
        prev_r <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lvl_r <= in_sensor_levels;
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.scan_en && hit) begin
      sum_r <= sum_r + weight;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.div_init) begin
      quo_r <= sum_abs[MAG_W-1:0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= quo_sh[MAG_W-1:0];
      rem_r <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
    if (cmd.err_load) begin
      lost_r <= (cnt_r == '0);
      err_r  <= (cnt_r != '0) ? err_new : last_good_r;
    end
    if (cmd.mul_p) begin
      acc_r <= PD_W'(prod);
    end else if (cmd.mul_d) begin
      acc_r <= acc_r + PD_W'(prod);
    end
    if (cmd.turn_en) begin
      turn_r <= pd_adj[PD_W-1:8];
    end
    if (cmd.speed_en) begin
      left_r  <= clamp_speed(lsum, limit_r);
      right_r <= clamp_speed(rsum, limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_stop) begin
        out_err_r   <= '0;
        out_lost_r  <= 1'b1;
        out_mask_r  <= '0;
        out_stop_r  <= 1'b1;
        out_right_r <= '0;
        out_left_r  <= '0;
      end else begin
        out_err_r   <= err_r;
        out_lost_r  <= lost_r;
        out_mask_r  <= mask_c;
        out_stop_r  <= 1'b0;
        out_right_r <= right_r;
        out_left_r  <= SPEED_W'(0) - {1'b0, left_r};
      end
    end
  end

  assign sts.sensors_ready = ready_r;
  assign sts.out_busy      = out_valid_r && !out_ready;

  assign out_valid         = out_valid_r;
  assign out_line_error    = out_err_r;
  assign out_line_lost     = out_lost_r;
  assign out_on_line_mask  = out_mask_r;
  assign out_stop_all      = out_stop_r;
  assign out_right_command = out_right_r;
  assign out_left_command  = out_left_r;

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("output became valid without a load");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stop_r) |->
      (out_lost_r && out_right_r == '0 && out_left_r == '0 && out_mask_r == '0))
    else $error("stop result carries nonzero fields");

  a_left_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_left_r <= 0))
    else $error("left command is positive");

endmodule

### rtl/line_follow_pd_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PD steering
// Turns one sample of sensor levels into a line error and wheel commands.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one request per control tick:
// the raw sensor levels. The output channel (out_valid/out_ready) returns one
// result per request: line error, lost flag, on-line mask, stop flag and the
// right and left wheel commands. The configuration channel (cfg_valid,
// cfg_ready always high) writes one register per request by index; write it
// only while no request is in flight.
// With sensors ready, a request goes from acceptance to a loaded result
// through one scan step per sensor, one restoring divider step per quotient
// bit (mag_w(SENSOR_COUNT) bits), and seven fixed steps around the two passes
// of the shared multiplier. With sensors not ready the request goes straight
// to the last step, which loads the stop result when the output register frees.
// A new request is taken only after the previous one reaches the output
// register, so the block never works on two samples at once; a stalled
// receiver holds at most one finished result plus one request in progress,
// which waits in its last step until the output register frees up.
// Reset clears all configuration, the error history and the output valid.
// ----------------------------------------------------------------------------
module line_follow_pd_steering #(
  parameter int SENSOR_COUNT = lfps_pkg::SENSOR_COUNT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [lfps_pkg::LEVEL_W-1:0]         in_sensor_levels,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lfps_pkg::ERR_W-1:0]    out_line_error,
  output logic                                 out_line_lost,
  output logic [lfps_pkg::LEVEL_W-1:0]         out_on_line_mask,
  output logic                                 out_stop_all,
  output logic [lfps_pkg::LIMIT_W-1:0]         out_right_command,
  output logic signed [lfps_pkg::SPEED_W-1:0]  out_left_command
);
  import lfps_pkg::*;

  localparam int IDX_W = $clog2(SENSOR_COUNT);

  lfps_cmd_t        cmd;
  lfps_sts_t        sts;
  logic [IDX_W-1:0] idx;

  // Registers are plain flops, so a write is always taken at once.
  assign cfg_ready = 1'b1;

  // The controller walks the steps; the datapath holds all arithmetic and
  // the output register.
  lfps_ctrl #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .idx      (idx)
  );

  lfps_dp #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sensor_levels  (in_sensor_levels),
    .cmd               (cmd),
    .idx               (idx),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_error    (out_line_error),
    .out_line_lost     (out_line_lost),
    .out_on_line_mask  (out_on_line_mask),
    .out_stop_all      (out_stop_all),
    .out_right_command (out_right_command),
    .out_left_command  (out_left_command)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PD steering testbench
// Feeds sensor samples through the valid/ready input channel, programs the
// register file between phases, and checks every result field against a
// cycle-free model of the steering math kept in a small scoreboard class.
// Directed samples come first, then random phases with random register
// settings, random input gaps and random back-pressure on the output.
// ----------------------------------------------------------------------------
module testbench;
  import lfps_pkg::*;

  // Cycles from an accepted request to its loaded result with eight sensors.
  localparam int REQ_LATENCY = 20;
  // Length of the one long receiver hold-off, in clock cycles.
  localparam int LONG_HOLD = 300;
  // Random phases and requests per phase; together with the directed part
  // this comes to roughly 1800 requests.
  localparam int PHASES = 8;
  localparam int PHASE_REQS = 222;
  // Register indexes that decode to nothing; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

  typedef struct {
    logic signed [ERR_W-1:0]   line_error;
    logic                      line_lost;
    logic [LEVEL_W-1:0]        on_line_mask;
    logic                      stop_all;
    logic [LIMIT_W-1:0]        right_command;
    logic signed [SPEED_W-1:0] left_command;
  } steer_result_t;

  // The scoreboard holds its own copy of the registers and the error history,
  // works out the steering result of every accepted request, and compares the
  // results that come out of the block in order.
  class steer_scoreboard;
    logic                      black_level   = 1'b0;
    logic [GAIN_W-1:0]         prop_gain     = '0;
    logic [GAIN_W-1:0]         deriv_gain    = '0;
    logic signed [SPEED_W-1:0] base_speed    = '0;
    logic [LIMIT_W-1:0]        speed_limit   = '0;
    logic                      sensors_ready = 1'b0;
    logic signed [ERR_W-1:0]   last_good_err = '0;
    logic signed [ERR_W-1:0]   prev_err      = '0;
    steer_result_t             steer_q[$];
    int                        fail_count    = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BLACK_LEVEL:   black_level   = data[0];
        CFG_PROP_GAIN:     prop_gain     = data;
        CFG_DERIV_GAIN:    deriv_gain    = data;
        CFG_BASE_SPEED:    base_speed    = data;
        CFG_SPEED_LIMIT:   speed_limit   = data[LIMIT_W-1:0];
        CFG_SENSORS_READY: sensors_ready = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [LEVEL_W-1:0] levels);
      steer_result_t r;
      int            sum;
      int            count;
      int            err;
      int            delta;
      longint        pd;
      longint        turn;
      longint        left;
      longint        right;
      longint        neg_left;
      r.line_error    = '0;
      r.line_lost     = 1'b1;
      r.on_line_mask  = '0;
      r.stop_all      = 1'b1;
      r.right_command = '0;
      r.left_command  = '0;
      // Unconfigured sensors give the stop result and leave the history alone.
      if (!sensors_ready) begin
        steer_q.push_back(r);
        return;
      end
      sum = 0;
      count = 0;
      for (int i = 0; i < LEVEL_W; i++) begin
        if (levels[i] == black_level) begin
          r.on_line_mask[i] = 1'b1;
          sum += 2 * i - (LEVEL_W - 1);
          count++;
        end
      end
      if (count > 0) begin
        err = sum / count;
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < -ERR_MAX) err = -ERR_MAX;
        last_good_err = err[ERR_W-1:0];
      end else begin
        err = last_good_err;
      end
      delta = err - prev_err;
      prev_err = err[ERR_W-1:0];
      pd = longint'(prop_gain) * err + longint'(deriv_gain) * delta;
      turn = pd / 256;
      if (turn > 32767) turn = 32767;
      if (turn < -32768) turn = -32768;
      left = longint'(base_speed) + turn;
      right = longint'(base_speed) - turn;
      if (left < 0) left = 0;
      if (left > longint'(speed_limit)) left = speed_limit;
      if (right < 0) right = 0;
      if (right > longint'(speed_limit)) right = speed_limit;
      neg_left = -left;
      r.line_error    = err[ERR_W-1:0];
      r.line_lost     = (count == 0);
      r.stop_all      = 1'b0;
      r.right_command = right[LIMIT_W-1:0];
      r.left_command  = neg_left[SPEED_W-1:0];
      steer_q.push_back(r);
    endfunction

    function void compare_field(string field, logic signed [31:0] want,
                                logic signed [31:0] seen);
      if (seen !== want) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, seen);
        fail_count++;
      end
    endfunction

    function void check_result(steer_result_t got);
      steer_result_t want;
      if (steer_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual error %0d",
                 $time, got.line_error);
        fail_count++;
        return;
      end
      want = steer_q.pop_front();
      compare_field("line_error", want.line_error, got.line_error);
      compare_field("line_lost", want.line_lost, got.line_lost);
      compare_field("on_line_mask", want.on_line_mask, got.on_line_mask);
      compare_field("stop_all", want.stop_all, got.stop_all);
      compare_field("right_command", want.right_command, got.right_command);
      compare_field("left_command", want.left_command, got.left_command);
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic [LEVEL_W-1:0]         in_sensor_levels;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [ERR_W-1:0]    out_line_error;
  logic                       out_line_lost;
  logic [LEVEL_W-1:0]         out_on_line_mask;
  logic                       out_stop_all;
  logic [LIMIT_W-1:0]         out_right_command;
  logic signed [SPEED_W-1:0]  out_left_command;

  // When calm is set neither side idles any more. hold_out asks the result
  // sink for one long hold-off, which it counts out on its own.
  bit calm = 1'b0;
  bit hold_out = 1'b0;

  steer_scoreboard sb = new;

  line_follow_pd_steering uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sensor_levels  (in_sensor_levels),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_line_error    (out_line_error),
    .out_line_lost     (out_line_lost),
    .out_on_line_mask  (out_on_line_mask),
    .out_stop_all      (out_stop_all),
    .out_right_command (out_right_command),
    .out_left_command  (out_left_command)
  );

  // 10 ns clock, starting low so the first rising edge is at 5 ns.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pick a register value, leaning on the extremes of a 16-bit word and
  // otherwise on a range that makes for useful steering.
  function automatic logic [15:0] pick_word(input logic [15:0] typical_max);
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      4: return 16'($urandom);
      default: return 16'($urandom_range(0, typical_max));
    endcase
  endfunction

  // Half of the samples look like a real line: a run of one to three adjacent
  // sensors at the black level. The rest are noise, all-black and all-white.
  function automatic logic [LEVEL_W-1:0] make_levels(input logic black);
    int                 width;
    int                 first;
    logic [LEVEL_W-1:0] run;
    width = $urandom_range(1, 3);
    first = $urandom_range(0, LEVEL_W - width);
    run = 8'((1 << width) - 1) << first;
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom);
      3: return 8'h00;
      4: return 8'hFF;
      default: return black ? run : ~run;
    endcase
  endfunction

  // Wait until every expected result has been taken from the block.
  task automatic wait_drained();
    while (sb.steer_q.size() != 0) @(posedge clk);
  endtask

  // Offer one sample of sensor levels, sometimes after an idle burst, and
  // note it in the scoreboard at the edge where the request is accepted.
  // Valid is left high so that a following request goes back to back.
  task automatic send_levels(input logic [LEVEL_W-1:0] levels);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sensor_levels <= levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(levels);
  endtask

  task automatic send_batch(input logic [LEVEL_W-1:0] list[$]);
    foreach (list[i]) send_levels(list[i]);
    in_valid <= 1'b0;
  endtask

  // Program all six registers once the block has gone idle. The ready flag
  // goes last so the other settings are in place when it turns on. Now and
  // then an undecoded index is written too, which must change nothing.
  task automatic write_regs(input logic [15:0] bl, kp, kd, base, limit, rdy);
    logic [CFG_DATA_W-1:0] data[6];
    data = '{bl, kp, kd, base, limit, rdy};
    wait_drained();
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= data[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(cfg_reg_t'(i), data[i]);
    end
    if ($urandom_range(0, 2) == 0) begin
      cfg_index <= $urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B;
      cfg_data <= 16'($urandom);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(cfg_index, cfg_data);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result sink. The outputs are sampled right after the rising edge, so the
  // values seen are the ones the handshake used at that edge. out_ready is
  // then decided for the next edge: random stall bursts, the one long
  // hold-off on request, and no stalls once calm is set.
  initial begin : result_sink
    int            stall;
    steer_result_t got;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        got.line_error    = out_line_error;
        got.line_lost     = out_line_lost;
        got.on_line_mask  = out_on_line_mask;
        got.stop_all      = out_stop_all;
        got.right_command = out_right_command;
        got.left_command  = out_left_command;
        sb.check_result(got);
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (hold_out) begin
        hold_out = 1'b0;
        stall = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [15:0] bl;
    logic [15:0] kp;
    logic [15:0] kd;
    logic [15:0] base;
    logic [15:0] limit;
    logic [15:0] rdy;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BLACK_LEVEL;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_sensor_levels <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset the sensors count as unconfigured, so the block
    // must answer with the stop result.
    send_batch('{8'h5A});

    // Unit proportional and half derivative gain, black is a high level. The
    // first sample sees no line and repeats the reset error; then the outermost
    // sensors, pairs, a lost line holding the last good error, and wider runs.
    write_regs(16'h0001, 16'h0100, 16'h0080, 16'd1000, 16'd2000, 16'h0001);
    send_batch('{8'h00, 8'h01, 8'h80, 8'h03, 8'hC0, 8'h00, 8'h18, 8'hFF, 8'h55,
                 8'hAA, 8'h0F, 8'hF0});

    // Black is a low level, full-scale gains, most negative base speed and a
    // limit whose top data bit must be dropped; both wheels clamp at zero.
    write_regs(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0001);
    send_batch('{8'h00, 8'hFE, 8'h7F, 8'hFF, 8'h80});

    // Largest base speed with the largest limit: one wheel saturates at the
    // limit while the other is pulled down by the turn.
    write_regs(16'h0001, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h0001);
    send_batch('{8'h01, 8'h80, 8'h02});

    // Sensors not ready: stop results, and the error history must survive.
    write_regs(16'h0001, 16'h0100, 16'h0100, 16'd500, 16'd1000, 16'h0000);
    send_batch('{8'h01, 8'hFF, 8'h00});

    // Ready again: a lost line repeats the error from before the stop.
    write_regs(16'h0001, 16'h0100, 16'h0100, 16'd500, 16'd1000, 16'h0001);
    send_batch('{8'h00, 8'h80});

    // Random phases, each with its own register setting. The ready flag is
    // mostly on, with random upper data bits that the block must ignore.
    for (int phase = 0; phase < PHASES; phase++) begin
      bl = 16'($urandom);
      kp = pick_word(16'h0400);
      kd = pick_word(16'h0400);
      base = pick_word(16'd20000);
      limit = pick_word(16'h7FFF);
      rdy = {15'($urandom), 1'($urandom_range(0, 7) != 0)};
      write_regs(bl, kp, kd, base, limit, rdy);
      if (phase == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_REQS; n++) begin
        // Long receiver hold-off while requests keep coming, so the block
        // fills up and has to drop in_ready.
        if (phase == 2 && n == 20) hold_out = 1'b1;
        // Sender pause in the middle of a phase until the block is empty.
        // A request was just accepted, so the wait always spans an edge.
        if (phase == 4 && n == 110) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        send_levels(make_levels(sb.black_level));
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    // Give a stray extra result time to show up.
    repeat (2 * REQ_LATENCY) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
rtl/lfps_pkg.sv
rtl/lfps_ctrl.sv
rtl/lfps_dp.sv
rtl/line_follow_pd_steering.sv
test/testbench.sv
